// File: sv/lhb_pkg.sv
// Shared types, codes and field widths for the latency histogram binner.
package lhb_pkg;

	localparam int KIND_W  = 2;
	localparam int CLASS_W = 3;
	localparam int LAT_W   = 48;
	localparam int SLOT_W  = 6;
	localparam int DATA_W  = 64;
	localparam int HIT_W   = 6;
	localparam int OUTC_W  = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_RECORD = 2'd0,
		KIND_LOAD   = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// record outcome codes
	localparam logic [OUTC_W-1:0] OUTC_SUCCESS = 2'd0;
	localparam logic [OUTC_W-1:0] OUTC_ERROR   = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_NONUSER = 2'd2;
	localparam logic [OUTC_W-1:0] OUTC_NONE    = 2'd0;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CLASS_W-1:0] op_class;
		logic [LAT_W-1:0]   latency;
		logic               is_error;
		logic               is_user;
		logic [SLOT_W-1:0]  slot;
		logic [LAT_W-1:0]   bound_value;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [HIT_W-1:0]  bucket_hit;
		logic [OUTC_W-1:0] counted;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_LAST_RD,
		ST_LAST_CHK,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic capture;
		logic clr_step;
		logic last_rd;
		logic last_chk;
		logic scan_rd;
		logic scan_chk;
		logic cnt_rd;
		logic cnt_wr;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic need_scan;
		logic need_cnt_rd;
		logic over_last;
		logic bound_hit;
		logic out_free;
	} sts_t;

endpackage

// File: sv/lhb_in_if.sv
// Input channel: valid/ready handshake carrying one binner item.
interface lhb_in_if import lhb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [CLASS_W-1:0] op_class;
	logic [LAT_W-1:0]   latency;
	logic               is_error;
	logic               is_user;
	logic [SLOT_W-1:0]  slot;
	logic [LAT_W-1:0]   bound_value;

	modport source (
		output valid, kind, op_class, latency, is_error, is_user, slot, bound_value,
		input  ready
	);
	modport sink (
		input  valid, kind, op_class, latency, is_error, is_user, slot, bound_value,
		output ready
	);
endinterface

// File: sv/lhb_out_if.sv
// Output channel: valid/ready handshake carrying one binner result.
interface lhb_out_if import lhb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic [HIT_W-1:0]  bucket_hit;
	logic [OUTC_W-1:0] counted;

	modport source (
		output valid, read_data, bucket_hit, counted,
		input  ready
	);
	modport sink (
		input  valid, read_data, bucket_hit, counted,
		output ready
	);
endinterface

// File: sv/lhb_ctrl.sv
// Controller state machine: sequences clear sweep, bound scan and counter updates.
module lhb_ctrl import lhb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR:    if (sts.clr_last) state_nx = ST_IDLE;
			ST_IDLE:     if (in_valid) state_nx = ST_DISPATCH;
			ST_DISPATCH: begin
				if (sts.need_scan) state_nx = ST_LAST_RD;
				else if (sts.need_cnt_rd) state_nx = ST_CNT_RD;
				else state_nx = ST_FINISH;
			end
			ST_LAST_RD:  state_nx = ST_LAST_CHK;
			ST_LAST_CHK: state_nx = sts.over_last ? ST_FINISH : ST_SCAN_RD;
			ST_SCAN_RD:  state_nx = ST_SCAN_CHK;
			ST_SCAN_CHK: state_nx = sts.bound_hit ? ST_CNT_RD : ST_SCAN_RD;
			ST_CNT_RD:   state_nx = sts.need_scan ? ST_CNT_WR : ST_FINISH;
			ST_CNT_WR:   state_nx = ST_FINISH;
			ST_FINISH:   if (sts.out_free) state_nx = ST_IDLE;
			default:     state_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR:    cmd.clr_step = 1'b1;
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.capture  = in_valid;
			end
			ST_DISPATCH: cmd = '0;
			ST_LAST_RD:  cmd.last_rd  = 1'b1;
			ST_LAST_CHK: cmd.last_chk = 1'b1;
			ST_SCAN_RD:  cmd.scan_rd  = 1'b1;
			ST_SCAN_CHK: cmd.scan_chk = 1'b1;
			ST_CNT_RD:   cmd.cnt_rd   = 1'b1;
			ST_CNT_WR:   cmd.cnt_wr   = 1'b1;
			ST_FINISH:   cmd.finish   = sts.out_free;
			default:     cmd = '0;
		endcase
	end

endmodule

// File: sv/lhb_datapath.sv
// Datapath: item register, bound and bucket memories, class counters, result register.
module lhb_datapath import lhb_pkg::*; #(
	parameter int NUM_BUCKETS = 32,
	parameter int NUM_CLASSES = 8,
	parameter int COUNT_BITS  = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cmd_t    cmd,
	output sts_t    sts,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t result
);

	localparam int DEPTH = NUM_CLASSES * NUM_BUCKETS;
	localparam int BAW   = $clog2(NUM_BUCKETS);
	localparam int HW    = $clog2(NUM_BUCKETS + 1);
	localparam int CW    = $clog2(DEPTH);
	localparam int CLW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam logic [SLOT_W-1:0] SLOT_SUM  = SLOT_W'(NUM_BUCKETS);
	localparam logic [SLOT_W-1:0] SLOT_SUCC = SLOT_W'(NUM_BUCKETS + 1);
	localparam logic [SLOT_W-1:0] SLOT_ERR  = SLOT_W'(NUM_BUCKETS + 2);
	localparam logic [SLOT_W-1:0] SLOT_NU   = SLOT_W'(NUM_BUCKETS + 3);

	item_t                  item_q;
	logic [LAT_W-1:0]       bnd_mem [NUM_BUCKETS];
	logic [LAT_W-1:0]       bnd_rd_q;
	logic [COUNT_BITS-1:0]  cnt_mem [DEPTH];
	logic [COUNT_BITS-1:0]  cnt_rd_q;
	logic [BAW-1:0]         idx_q;
	logic [HW-1:0]          hit_q;
	logic [CW-1:0]          clr_q;
	logic [DATA_W-1:0]      sum_q  [NUM_CLASSES];
	logic [COUNT_BITS-1:0]  succ_q [NUM_CLASSES];
	logic [COUNT_BITS-1:0]  err_q  [NUM_CLASSES];
	logic [COUNT_BITS-1:0]  nu_q   [NUM_CLASSES];
	logic                   out_valid_q;
	result_t                result_q;

	logic                   cls_ok;
	logic [CLW-1:0]         cls;
	logic                   is_rec, is_load, is_read;
	logic                   slot_bkt;
	logic [BAW-1:0]         bnd_addr;
	logic [BAW-1:0]         bkt_sel;
	logic [CW-1:0]          cnt_addr;
	logic [COUNT_BITS-1:0]  cnt_inc;
	result_t                res_nx;

	assign cls      = item_q.op_class[CLW-1:0];
	assign cls_ok   = int'(item_q.op_class) < NUM_CLASSES;
	assign is_rec   = kind_t'(item_q.kind) == KIND_RECORD;
	assign is_load  = kind_t'(item_q.kind) == KIND_LOAD;
	assign is_read  = kind_t'(item_q.kind) == KIND_READ;
	assign slot_bkt = int'(item_q.slot) < NUM_BUCKETS;

	assign sts.clr_last    = clr_q == CW'(DEPTH - 1);
	assign sts.need_scan   = is_rec && cls_ok && item_q.is_user && !item_q.is_error;
	assign sts.need_cnt_rd = is_read && cls_ok && slot_bkt;
	assign sts.over_last   = item_q.latency > bnd_rd_q;
	assign sts.bound_hit   = bnd_rd_q >= item_q.latency;
	assign sts.out_free    = !out_valid_q || out_ready;

	// item register
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
	end

	// bound memory: load on finish, read last entry or scan entry
	assign bnd_addr = cmd.last_rd ? BAW'(NUM_BUCKETS - 1) : idx_q;

	always_ff @(posedge clk) begin
		if (cmd.finish && is_load && slot_bkt) bnd_mem[item_q.slot[BAW-1:0]] <= item_q.bound_value;
		if (cmd.last_rd || cmd.scan_rd) bnd_rd_q <= bnd_mem[bnd_addr];
	end

	// scan index and chosen bucket
	always_ff @(posedge clk) begin
		if (cmd.last_chk) begin
			idx_q <= '0;
			hit_q <= HW'(NUM_BUCKETS);
		end else if (cmd.scan_chk) begin
			if (sts.bound_hit) hit_q <= HW'(idx_q);
			else idx_q <= idx_q + 1'b1;
		end
	end

	// bucket counter memory, swept to zero after reset
	assign bkt_sel  = sts.need_scan ? hit_q[BAW-1:0] : item_q.slot[BAW-1:0];
	assign cnt_addr = CW'(int'(cls) * NUM_BUCKETS + int'(bkt_sel));
	assign cnt_inc  = (&cnt_rd_q) ? cnt_rd_q : cnt_rd_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step && !sts.clr_last) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) cnt_mem[clr_q] <= '0;
		else if (cmd.cnt_wr) cnt_mem[cnt_addr] <= cnt_inc;
		if (cmd.cnt_rd) cnt_rd_q <= cnt_mem[cnt_addr];
	end

	// per-class sums and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				sum_q[i]  <= '0;
				succ_q[i] <= '0;
				err_q[i]  <= '0;
				nu_q[i]   <= '0;
			end
		end else if (cmd.finish && is_rec && cls_ok) begin
			if (!item_q.is_user) begin
				if (!(&nu_q[cls])) nu_q[cls] <= nu_q[cls] + 1'b1;
			end else if (item_q.is_error) begin
				if (!(&err_q[cls])) err_q[cls] <= err_q[cls] + 1'b1;
			end else begin
				sum_q[cls] <= sum_q[cls] + DATA_W'(item_q.latency);
				if (!(&succ_q[cls])) succ_q[cls] <= succ_q[cls] + 1'b1;
			end
		end
	end

	// result formation
	always_comb begin
		res_nx = '0;
		if (cls_ok) begin
			if (is_rec) begin
				if (!item_q.is_user) begin
					res_nx.counted = OUTC_NONUSER;
				end else if (item_q.is_error) begin
					res_nx.counted = OUTC_ERROR;
				end else begin
					res_nx.counted    = OUTC_SUCCESS;
					res_nx.bucket_hit = HIT_W'(hit_q);
				end
			end else if (is_read) begin
				if (slot_bkt) res_nx.read_data = DATA_W'(cnt_rd_q);
				else if (item_q.slot == SLOT_SUM) res_nx.read_data = sum_q[cls];
				else if (item_q.slot == SLOT_SUCC) res_nx.read_data = DATA_W'(succ_q[cls]);
				else if (item_q.slot == SLOT_ERR) res_nx.read_data = DATA_W'(err_q[cls]);
				else if (item_q.slot == SLOT_NU) res_nx.read_data = DATA_W'(nu_q[cls]);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) result_q <= res_nx;
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

// File: sv/latency_histogram_binner_core.sv
// Per-class latency histogram binner: top level joining controller and datapath.
//
// Usage: items arrive on item_ch (valid/ready). kind selects record, bound
// load or counter read. Every item yields exactly one transaction on
// result_ch: read_data for reads, bucket_hit and counted for records.
// Sequencing: one item at a time. Loads, reads of sums and class
// counters, and non-success records go from dispatch straight to the
// result. A bucket count read first reads the counter memory. A success
// record reads the last bound and, if the latency is above it, goes to
// the result; else it scans the bound memory from entry 0 (one memory
// read, one compare per bound) until the first bound at or above the
// latency, then does a read-modify-write of the bucket counter. The
// single-port bound memory scan sets the length of this sequence.
// Reset: arst_n clears counters and sums; the bucket counter memory is then
// swept to zero, one entry a cycle, all NUM_CLASSES*NUM_BUCKETS entries (256 by
// default), with ready low. Bounds are undefined until loaded.
// Stall: the result sits in an output register; the next item is accepted
// while it waits, and its result is held until result_ch drains.
module latency_histogram_binner_core import lhb_pkg::*; #(
	parameter int NUM_BUCKETS = 32,
	parameter int NUM_CLASSES = 8,
	parameter int COUNT_BITS  = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	lhb_in_if.sink         item_ch,
	lhb_out_if.source      result_ch
);

	cmd_t    cmd;
	sts_t    sts;
	item_t   item;
	result_t result;

	// pack the incoming payload for the datapath
	assign item.kind        = item_ch.kind;
	assign item.op_class    = item_ch.op_class;
	assign item.latency     = item_ch.latency;
	assign item.is_error    = item_ch.is_error;
	assign item.is_user     = item_ch.is_user;
	assign item.slot        = item_ch.slot;
	assign item.bound_value = item_ch.bound_value;

	// ready only while the controller waits for a new item
	assign item_ch.ready = cmd.in_ready;

	lhb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_ch.valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	lhb_datapath #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.NUM_CLASSES (NUM_CLASSES),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (result_ch.ready),
		.out_valid (result_ch.valid),
		.result    (result)
	);

	// drive the result transaction from the output register
	assign result_ch.read_data  = result.read_data;
	assign result_ch.bucket_hit = result.bucket_hit;
	assign result_ch.counted    = result.counted;

endmodule
